### rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcm_pkg;

   // Matrix size and storage
   localparam int DIM_DEFAULT   = 16;
   localparam int PAIRS_DEFAULT = (DIM_DEFAULT * (DIM_DEFAULT - 1)) / 2;
   localparam int VAL_W         = 16;
   localparam int IDX_FIELD_W   = 6;

   // Stream widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 3;

   // Q2.14 constants
   localparam logic signed [VAL_W-1:0] Q_ONE  = 16'sd16384;
   localparam logic signed [VAL_W-1:0] Q_ZERO = 16'sd0;

   // Request modes
   localparam logic [1:0] MODE_WRITE    = 2'd0;
   localparam logic [1:0] MODE_READ     = 2'd1;
   localparam logic [1:0] MODE_EXTREMES = 2'd2;
   localparam logic [1:0] MODE_CLUSTER  = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_READ     = 2'd0;
   localparam logic [1:0] KIND_EXTREMES = 2'd1;
   localparam logic [1:0] KIND_MEMBER   = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERROR,
      ST_READ_EMIT,
      ST_EXT_ADDR,
      ST_EXT_CMP,
      ST_EXT_EMIT,
      ST_LEAD,
      ST_SCAN_ADDR,
      ST_SCAN_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic above_ref;
      logic below_ref;
   } cmp_result_type;

endpackage

`default_nettype wire

### rtl/threshold_cluster_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

// Symmetric similarity matrix (Q2.14, packed lower triangle in one RAM) with
// leader clustering. Requests carry mode in req_tuser; writes give no result
// unless an index is out of range; reads and index errors give one result;
// extremes walk all P = DIM*(DIM-1)/2 slots; a clustering run takes leader
// steps, a scan of the pairs for each leader and emit steps, and emits
// exactly DIM member results. Every walk goes through the single RAM read
// port and the one compare unit. req_tready is low while a request is at
// work; stalls on rsp_tready hold the block in its emit states. The user
// must write the threshold on the csr port only while the block is idle;
// the block itself does not enforce this.
module threshold_cluster_matrix #(
   parameter int DIM = tcm_pkg::DIM_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // csr_data: threshold
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tcm_pkg::VAL_W-1:0]       csr_data,
   // req_tdata: row[5:0], col[11:6], entry_value[27:12], zero pad[31:28]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [tcm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: mode[1:0]
   input  wire logic [tcm_pkg::REQ_USER_W-1:0]  req_tuser,
   // rsp_tdata: data_value[15:0], low_value[31:16], cluster_number[37:32],
   //            member_index[43:38], zero pad[47:44]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [tcm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser: kind[1:0], cluster_end[2]
   output logic [tcm_pkg::RSP_USER_W-1:0]       rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int PAIRS  = (DIM * (DIM - 1)) / 2;
   localparam int SLOT_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int IDX_W  = $clog2(DIM);
   localparam int PROD_W = 2 * IDX_W;
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIM - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PAIRS - 1);

   tcm_pkg::state_type state_ff, state_in;

   logic signed [tcm_pkg::VAL_W-1:0] thr_ff, thr_in;
   logic signed [tcm_pkg::VAL_W-1:0] hi_ff, hi_in;
   logic signed [tcm_pkg::VAL_W-1:0] lo_ff, lo_in;
   logic [DIM-1:0]    flags_ff, flags_in;
   logic [DIM-1:0]    mask_ff, mask_in;
   logic [IDX_W-1:0]  lead_ff, lead_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  cnum_ff, cnum_in;
   logic [SLOT_W-1:0] s_ff, s_in;
   logic              diag_ff, diag_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tcm_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [tcm_pkg::RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Request decode
   logic                             req_fire;
   logic [1:0]                       req_mode;
   logic [tcm_pkg::IDX_FIELD_W-1:0]  req_row, req_col;
   logic signed [tcm_pkg::VAL_W-1:0] req_value;
   logic                             idx_bad;
   logic                             out_free;

   // Slot address
   logic [IDX_W-1:0]  slot_hi, slot_lo;
   logic [PROD_W-1:0] slot_prod;
   logic [SLOT_W-1:0] slot_addr;

   // RAM and compare unit
   logic                             ram_wr_en, ram_rd_en;
   logic [SLOT_W-1:0]                ram_rd_addr;
   logic [tcm_pkg::VAL_W-1:0]        ram_rd_data;
   logic signed [tcm_pkg::VAL_W-1:0] rd_value;
   logic signed [tcm_pkg::VAL_W-1:0] cmp_upper;
   tcm_pkg::cmp_result_type          cmp_res;

   // Cluster emit helpers
   logic [DIM-1:0] above_k;
   logic           cluster_end;
   logic           all_done;

   // Result being produced this cycle
   logic                             emit;
   logic [1:0]                       emit_kind;
   logic signed [tcm_pkg::VAL_W-1:0] emit_data, emit_low;
   logic [tcm_pkg::IDX_FIELD_W-1:0]  emit_cnum, emit_member;
   logic                             emit_end, emit_last;

   assign req_tready = state_ff == tcm_pkg::ST_IDLE;
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign req_mode   = req_tuser;
   assign req_row    = req_tdata[5:0];
   assign req_col    = req_tdata[11:6];
   assign req_value  = signed'(req_tdata[27:12]);
   assign idx_bad    = ({1'b0, req_row} >= 7'(DIM)) || ({1'b0, req_col} >= 7'(DIM));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_value   = signed'(ram_rd_data);
   assign all_done   = &flags_ff;

   // Pick the pair for the packed slot: larger index first
   always_comb begin
      if (state_ff == tcm_pkg::ST_IDLE) begin
         if (req_row > req_col) begin
            slot_hi = req_row[IDX_W-1:0];
            slot_lo = req_col[IDX_W-1:0];
         end else begin
            slot_hi = req_col[IDX_W-1:0];
            slot_lo = req_row[IDX_W-1:0];
         end
      end else begin
         slot_hi = j_ff;
         slot_lo = lead_ff;
      end
   end

   // slot = hi*(hi-1)/2 + lo
   assign slot_prod = PROD_W'(slot_hi) * PROD_W'(slot_hi - 1'b1);
   assign slot_addr = SLOT_W'((slot_prod >> 1) + PROD_W'(slot_lo));

   assign ram_rd_addr = (state_ff == tcm_pkg::ST_EXT_ADDR) ? s_ff : slot_addr;

   tcm_ram #(
      .WIDTH (tcm_pkg::VAL_W),
      .DEPTH (PAIRS)
   ) u_tcm_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_addr),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cmp_upper = (state_ff == tcm_pkg::ST_EXT_CMP) ? hi_ff : thr_ff;

   tcm_cmp u_tcm_cmp (
      .operand   (rd_value),
      .upper_ref (cmp_upper),
      .lower_ref (lo_ff),
      .result    (cmp_res)
   );

   // Members above the current emit position
   always_comb begin
      for (int b = 0; b < DIM; b++) begin
         above_k[b] = b > int'(k_ff);
      end
      cluster_end = ~|(mask_ff & above_k);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  tcm_pkg::MODE_WRITE:
                     state_in = idx_bad ? tcm_pkg::ST_ERROR : tcm_pkg::ST_IDLE;
                  tcm_pkg::MODE_READ:
                     state_in = idx_bad ? tcm_pkg::ST_ERROR : tcm_pkg::ST_READ_EMIT;
                  tcm_pkg::MODE_EXTREMES: state_in = tcm_pkg::ST_EXT_ADDR;
                  tcm_pkg::MODE_CLUSTER:  state_in = tcm_pkg::ST_LEAD;
                  default:                state_in = tcm_pkg::ST_IDLE;
               endcase
            end
         end
         tcm_pkg::ST_ERROR, tcm_pkg::ST_READ_EMIT, tcm_pkg::ST_EXT_EMIT: begin
            if (out_free) begin
               state_in = tcm_pkg::ST_IDLE;
            end
         end
         tcm_pkg::ST_EXT_ADDR: state_in = tcm_pkg::ST_EXT_CMP;
         tcm_pkg::ST_EXT_CMP: begin
            state_in = (s_ff == LAST_SLOT) ? tcm_pkg::ST_EXT_EMIT : tcm_pkg::ST_EXT_ADDR;
         end
         tcm_pkg::ST_LEAD: begin
            if (!flags_ff[lead_ff]) begin
               state_in = (lead_ff == LAST_IDX) ? tcm_pkg::ST_EMIT : tcm_pkg::ST_SCAN_ADDR;
            end
         end
         tcm_pkg::ST_SCAN_ADDR: begin
            if (flags_ff[j_ff]) begin
               state_in = (j_ff == LAST_IDX) ? tcm_pkg::ST_EMIT : tcm_pkg::ST_SCAN_ADDR;
            end else begin
               state_in = tcm_pkg::ST_SCAN_CMP;
            end
         end
         tcm_pkg::ST_SCAN_CMP: begin
            state_in = (j_ff == LAST_IDX) ? tcm_pkg::ST_EMIT : tcm_pkg::ST_SCAN_ADDR;
         end
         tcm_pkg::ST_EMIT: begin
            if (mask_ff[k_ff] && out_free && cluster_end) begin
               state_in = all_done ? tcm_pkg::ST_IDLE : tcm_pkg::ST_LEAD;
            end
         end
         default: state_in = tcm_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and register next values
   always_comb begin
      thr_in      = csr_valid ? signed'(csr_data) : thr_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      flags_in    = flags_ff;
      mask_in     = mask_ff;
      lead_in     = lead_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      cnum_in     = cnum_ff;
      s_in        = s_ff;
      diag_in     = diag_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      emit        = 1'b0;
      emit_kind   = tcm_pkg::KIND_READ;
      emit_data   = tcm_pkg::Q_ZERO;
      emit_low    = tcm_pkg::Q_ZERO;
      emit_cnum   = '0;
      emit_member = '0;
      emit_end    = 1'b0;
      emit_last   = 1'b0;

      unique case (state_ff)
         tcm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  tcm_pkg::MODE_WRITE: begin
                     ram_wr_en = !idx_bad && (req_row != req_col);
                  end
                  tcm_pkg::MODE_READ: begin
                     ram_rd_en = !idx_bad;
                     diag_in   = req_row == req_col;
                  end
                  tcm_pkg::MODE_EXTREMES: begin
                     hi_in = tcm_pkg::Q_ZERO;
                     lo_in = tcm_pkg::Q_ONE;
                     s_in  = '0;
                  end
                  tcm_pkg::MODE_CLUSTER: begin
                     flags_in = '0;
                     lead_in  = '0;
                     cnum_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         tcm_pkg::ST_ERROR: begin
            emit      = out_free;
            emit_kind = tcm_pkg::KIND_ERROR;
            emit_last = 1'b1;
         end
         tcm_pkg::ST_READ_EMIT: begin
            emit      = out_free;
            emit_kind = tcm_pkg::KIND_READ;
            emit_data = diag_ff ? tcm_pkg::Q_ONE : rd_value;
            emit_last = 1'b1;
         end
         tcm_pkg::ST_EXT_ADDR: begin
            ram_rd_en = 1'b1;
         end
         tcm_pkg::ST_EXT_CMP: begin
            // Track running maximum and minimum
            if (cmp_res.above_ref) begin
               hi_in = rd_value;
            end
            if (cmp_res.below_ref) begin
               lo_in = rd_value;
            end
            if (s_ff != LAST_SLOT) begin
               s_in = s_ff + 1'b1;
            end
         end
         tcm_pkg::ST_EXT_EMIT: begin
            emit      = out_free;
            emit_kind = tcm_pkg::KIND_EXTREMES;
            emit_data = hi_ff;
            emit_low  = lo_ff;
            emit_last = 1'b1;
         end
         tcm_pkg::ST_LEAD: begin
            // Open a cluster at the next free item, else skip it
            if (!flags_ff[lead_ff]) begin
               flags_in[lead_ff] = 1'b1;
               mask_in           = '0;
               mask_in[lead_ff]  = 1'b1;
               k_in              = lead_ff;
               if (lead_ff != LAST_IDX) begin
                  j_in = lead_ff + 1'b1;
               end
            end else if (lead_ff != LAST_IDX) begin
               lead_in = lead_ff + 1'b1;
            end
         end
         tcm_pkg::ST_SCAN_ADDR: begin
            if (flags_ff[j_ff]) begin
               if (j_ff != LAST_IDX) begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         tcm_pkg::ST_SCAN_CMP: begin
            // Claim the candidate when strictly above threshold
            if (cmp_res.above_ref) begin
               flags_in[j_ff] = 1'b1;
               mask_in[j_ff]  = 1'b1;
            end
            if (j_ff != LAST_IDX) begin
               j_in = j_ff + 1'b1;
            end
         end
         tcm_pkg::ST_EMIT: begin
            if (mask_ff[k_ff]) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_kind   = tcm_pkg::KIND_MEMBER;
                  emit_cnum   = tcm_pkg::IDX_FIELD_W'(cnum_ff);
                  emit_member = tcm_pkg::IDX_FIELD_W'(k_ff);
                  emit_end    = cluster_end;
                  emit_last   = cluster_end && all_done;
                  if (cluster_end) begin
                     cnum_in = cnum_ff + 1'b1;
                     if (lead_ff != LAST_IDX) begin
                        lead_in = lead_ff + 1'b1;
                     end
                  end else if (k_ff != LAST_IDX) begin
                     k_in = k_ff + 1'b1;
                  end
               end
            end else if (k_ff != LAST_IDX) begin
               k_in = k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Output register: load a new result or drop the taken one
   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, emit_member, emit_cnum, emit_low, emit_data};
         rsp_user_in  = {emit_end, emit_kind};
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= tcm_pkg::Q_ZERO;
         flags_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         flags_ff     <= flags_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      mask_ff     <= mask_in;
      lead_ff     <= lead_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      cnum_ff     <= cnum_in;
      s_ff        <= s_in;
      diag_ff     <= diag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/tcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcm_ram #(
   parameter int WIDTH = tcm_pkg::VAL_W,
   parameter int DEPTH = tcm_pkg::PAIRS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/tcm_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module tcm_cmp (
   input  wire logic signed [tcm_pkg::VAL_W-1:0] operand,
   input  wire logic signed [tcm_pkg::VAL_W-1:0] upper_ref,
   input  wire logic signed [tcm_pkg::VAL_W-1:0] lower_ref,
   output tcm_pkg::cmp_result_type               result
);

   // Signed compare against both references
   always_comb begin
      result.above_ref = operand > upper_ref;
      result.below_ref = operand < lower_ref;
   end

endmodule

`default_nettype wire

### rtl/tcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tcm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [tcm_pkg::REQ_USER_W-1:0] req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [tcm_pkg::RSP_USER_W-1:0] rsp_tuser,
   input wire logic                           rsp_tlast
);

   // Single-result kinds always close their request
   `ASSERT_IMPLY(a_error_last, clock, reset, rsp_tvalid && rsp_tuser[1:0] == tcm_pkg::KIND_ERROR, rsp_tlast, "index error result without tlast")
   `ASSERT_IMPLY(a_single_last, clock, reset, rsp_tvalid && (rsp_tuser[1:0] == tcm_pkg::KIND_READ || rsp_tuser[1:0] == tcm_pkg::KIND_EXTREMES), rsp_tlast, "read or extremes result without tlast")

   // The final member of a run also closes its cluster
   `ASSERT_IMPLY(a_last_member_end, clock, reset, rsp_tvalid && rsp_tuser[1:0] == tcm_pkg::KIND_MEMBER && rsp_tlast, rsp_tuser[2], "last member without cluster end")

   // Anything but a write keeps the block busy for the next cycle
   `ASSERT_NEXT(a_busy_after_cmd, clock, reset, req_tvalid && req_tready && req_tuser != tcm_pkg::MODE_WRITE, !req_tready, "ready right after a multi-cycle request")

   // A stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

endmodule

bind threshold_cluster_matrix tcm_checker u_tcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int DIM              = tcm_pkg::DIM_DEFAULT;
   localparam int PAIRS            = tcm_pkg::PAIRS_DEFAULT;
   localparam int QUIET_LIMIT      = 3000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int PHASE_COUNT      = 4;
   localparam int MIXED_PER_PHASE  = 8;
   localparam int REFILL_PER_PHASE = 12;

   // How matrix entries are chosen during a phase
   typedef enum int {
      FILL_ANY,
      FILL_HIGH,
      FILL_NEG,
      FILL_NEAR
   } fill_style_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] data_value;
      logic signed [15:0] low_value;
      logic [5:0]         cluster_number;
      logic [5:0]         member_index;
      logic               cluster_end;
      logic               last;
   } matrix_result_type;

   // One directed request; answer is typed in only where it is obvious
   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [15:0] value;
      logic        typed;
      logic [1:0]  kind;
      logic [15:0] data;
   } probe_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [tcm_pkg::VAL_W-1:0]      csr_data   = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tcm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [tcm_pkg::REQ_USER_W-1:0] req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [tcm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [tcm_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                           rsp_tlast;

   // Mirror of the matrix and the join level
   logic signed [15:0] pair_mirror [PAIRS];
   logic signed [15:0] join_level = '0;
   matrix_result_type  answers_due [$];
   int                 mismatch_count = 0;
   int                 quiet_cycles = 0;
   int                 stall_left = 0;
   bit                 calm = 1'b0;

   probe_type probe_table [0:21] = '{
      '{tcm_pkg::MODE_READ,  6'd0,  6'd0,  16'h0000, 1'b1, tcm_pkg::KIND_READ,
        tcm_pkg::Q_ONE},
      '{tcm_pkg::MODE_READ,  6'd15, 6'd15, 16'h0000, 1'b1, tcm_pkg::KIND_READ,
        tcm_pkg::Q_ONE},
      '{tcm_pkg::MODE_WRITE, 6'd63, 6'd0,  16'h1234, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000},
      '{tcm_pkg::MODE_WRITE, 6'd0,  6'd63, 16'h1234, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000},
      '{tcm_pkg::MODE_READ,  6'd16, 6'd3,  16'h0000, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000},
      '{tcm_pkg::MODE_READ,  6'd3,  6'd16, 16'h0000, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000},
      '{tcm_pkg::MODE_WRITE, 6'd42, 6'd21, 16'hAAAA, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000},
      '{tcm_pkg::MODE_READ,  6'd21, 6'd42, 16'h5555, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000},
      '{tcm_pkg::MODE_WRITE, 6'd5,  6'd5,  16'h0123, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_READ,  6'd5,  6'd5,  16'h0000, 1'b1, tcm_pkg::KIND_READ,
        tcm_pkg::Q_ONE},
      '{tcm_pkg::MODE_WRITE, 6'd15, 6'd0,  16'h7FFF, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_READ,  6'd0,  6'd15, 16'h0000, 1'b1, tcm_pkg::KIND_READ,  16'h7FFF},
      '{tcm_pkg::MODE_WRITE, 6'd14, 6'd13, 16'h8000, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_READ,  6'd13, 6'd14, 16'h0000, 1'b1, tcm_pkg::KIND_READ,  16'h8000},
      '{tcm_pkg::MODE_WRITE, 6'd1,  6'd0,  16'h4000, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_READ,  6'd0,  6'd1,  16'h0000, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_WRITE, 6'd0,  6'd1,  16'hFFFF, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_READ,  6'd1,  6'd0,  16'h0000, 1'b1, tcm_pkg::KIND_READ,  16'hFFFF},
      '{tcm_pkg::MODE_WRITE, 6'd15, 6'd14, 16'h5555, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_READ,  6'd14, 6'd15, 16'h0000, 1'b0, tcm_pkg::KIND_READ,  16'h0000},
      '{tcm_pkg::MODE_READ,  6'd63, 6'd63, 16'h0000, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000},
      '{tcm_pkg::MODE_WRITE, 6'd16, 6'd16, 16'hFFFF, 1'b1, tcm_pkg::KIND_ERROR, 16'h0000}
   };

   threshold_cluster_matrix #(.DIM(DIM)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int slot_index(int a, int b);
      int hi;
      int lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      return hi * (hi - 1) / 2 + lo;
   endfunction

   function automatic logic signed [15:0] similarity(int a, int b);
      if (a == b)
         return tcm_pkg::Q_ONE;
      return pair_mirror[slot_index(a, b)];
   endfunction

   function automatic matrix_result_type make_result(logic [1:0] kind,
                                                     logic signed [15:0] data,
                                                     logic signed [15:0] low,
                                                     logic [5:0] cnum,
                                                     logic [5:0] member,
                                                     logic cend,
                                                     logic last);
      matrix_result_type r;
      r.kind           = kind;
      r.data_value     = data;
      r.low_value      = low;
      r.cluster_number = cnum;
      r.member_index   = member;
      r.cluster_end    = cend;
      r.last           = last;
      return r;
   endfunction

   // Append one expected result at the back of the queue
   function automatic void queue_answer(matrix_result_type r);
      answers_due = {answers_due, r};
   endfunction

   function automatic string describe(matrix_result_type r);
      return $sformatf("kind %0d data %0d low %0d cluster %0d member %0d end %0b last %0b",
                       r.kind, r.data_value, r.low_value, r.cluster_number,
                       r.member_index, r.cluster_end, r.last);
   endfunction

   function automatic logic signed [15:0] pick_value(fill_style_type style);
      case (style)
         FILL_HIGH: return 16'($urandom_range(16385, 32767));
         FILL_NEG:  return 16'($urandom_range(32768, 65535));
         FILL_NEAR: begin
            // Land on and around the join level to hit the strict compare
            case ($urandom_range(0, 4))
               0:       return join_level;
               1:       return join_level + 16'sd1;
               2:       return join_level - 16'sd1;
               default: return 16'($urandom);
            endcase
         end
         default:   return 16'($urandom);
      endcase
   endfunction

   task automatic note_fault(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // Work out what the block answers to one request and update the mirror
   task automatic compute_matrix_answer(logic [1:0] mode, int row, int col,
                                        logic signed [15:0] value);
      logic signed [15:0] top;
      logic signed [15:0] bottom;
      bit taken [DIM];
      int members [$];
      int cnum;
      if ((mode == tcm_pkg::MODE_WRITE || mode == tcm_pkg::MODE_READ) &&
          (row >= DIM || col >= DIM)) begin
         queue_answer(make_result(tcm_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b0, 1'b1));
      end else if (mode == tcm_pkg::MODE_WRITE) begin
         if (row != col)
            pair_mirror[slot_index(row, col)] = value;
      end else if (mode == tcm_pkg::MODE_READ) begin
         queue_answer(make_result(tcm_pkg::KIND_READ, similarity(row, col), '0, '0, '0,
                                  1'b0, 1'b1));
      end else if (mode == tcm_pkg::MODE_EXTREMES) begin
         top    = tcm_pkg::Q_ZERO;
         bottom = tcm_pkg::Q_ONE;
         for (int s = 0; s < PAIRS; s++) begin
            if (pair_mirror[s] > top)
               top = pair_mirror[s];
            if (pair_mirror[s] < bottom)
               bottom = pair_mirror[s];
         end
         queue_answer(make_result(tcm_pkg::KIND_EXTREMES, top, bottom, '0, '0, 1'b0, 1'b1));
      end else begin
         // Leader clustering: each free item claims later free items above the level
         cnum = 0;
         foreach (taken[i])
            taken[i] = 1'b0;
         for (int lead = 0; lead < DIM; lead++) begin
            if (!taken[lead]) begin
               taken[lead] = 1'b1;
               members.delete();
               members = {members, lead};
               for (int j = lead + 1; j < DIM; j++) begin
                  if (!taken[j] && similarity(lead, j) > join_level) begin
                     taken[j] = 1'b1;
                     members = {members, j};
                  end
               end
               foreach (members[k])
                  queue_answer(make_result(tcm_pkg::KIND_MEMBER, '0, '0, 6'(cnum),
                                           6'(members[k]), k == members.size() - 1,
                                           1'b0));
               cnum++;
            end
         end
         answers_due[answers_due.size() - 1].last = 1'b1;
      end
   endtask

   // Present one request and hold it until accepted
   task automatic send_request(logic [1:0] mode, logic [5:0] row, logic [5:0] col,
                               logic [15:0] value);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, value, col, row};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue_request(logic [1:0] mode, int row, int col,
                                logic signed [15:0] value);
      send_request(mode, row[5:0], col[5:0], value);
      compute_matrix_answer(mode, row, col, value);
   endtask

   // Drop the request line and wait until every answer is in
   task automatic drain_answers();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_join_level(logic signed [15:0] level);
      drain_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= level;
      do @(posedge clock); while (!csr_ready);
      join_level = level;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side backpressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      matrix_result_type got;
      matrix_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = make_result(rsp_tuser[1:0], rsp_tdata[15:0], rsp_tdata[31:16],
                           rsp_tdata[37:32], rsp_tdata[43:38], rsp_tuser[2], rsp_tlast);
         if (answers_due.size() == 0) begin
            note_fault({"result with nothing expected: ", describe(got)});
         end else begin
            want = answers_due.pop_front();
            if (got.kind !== want.kind || got.data_value !== want.data_value ||
                got.low_value !== want.low_value ||
                got.cluster_number !== want.cluster_number ||
                got.member_index !== want.member_index ||
                got.cluster_end !== want.cluster_end || got.last !== want.last)
               note_fault({"expected ", describe(want), " got ", describe(got)});
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("threshold_cluster_matrix regression: fail");
         $finish;
      end
   end

   initial begin
      fill_style_type     style;
      logic signed [15:0] level;
      int                 pick;
      int                 row;
      int                 col;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests
      foreach (probe_table[n]) begin
         send_request(probe_table[n].mode, probe_table[n].row, probe_table[n].col,
                      probe_table[n].value);
         if (probe_table[n].typed)
            queue_answer(make_result(probe_table[n].kind, probe_table[n].data,
                                     '0, '0, '0, 1'b0, 1'b1));
         else
            compute_matrix_answer(probe_table[n].mode, probe_table[n].row,
                                  probe_table[n].col, probe_table[n].value);
      end

      // Phases: set the level, fill or refresh the matrix, then mixed traffic
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         style = fill_style_type'(phase);
         case (phase)
            0:       level = 16'($urandom_range(0, 16384));
            1:       level = 16'sh7FFF;
            2:       level = 16'sh8000;
            default: level = 16'($urandom);
         endcase
         set_join_level(level);
         calm = (phase == PHASE_COUNT - 1);

         if (phase == 0) begin
            for (int hi = 1; hi < DIM; hi++) begin
               for (int lo = 0; lo < hi; lo++) begin
                  if ($urandom_range(0, 1))
                     issue_request(tcm_pkg::MODE_WRITE, hi, lo, pick_value(style));
                  else
                     issue_request(tcm_pkg::MODE_WRITE, lo, hi, pick_value(style));
               end
            end
         end else begin
            // Rewrite a handful of pairs in the style of this phase
            repeat (REFILL_PER_PHASE) begin
               row = $urandom_range(1, DIM - 1);
               col = $urandom_range(0, row - 1);
               if ($urandom_range(0, 1))
                  issue_request(tcm_pkg::MODE_WRITE, row, col, pick_value(style));
               else
                  issue_request(tcm_pkg::MODE_WRITE, col, row, pick_value(style));
            end
         end
         issue_request(tcm_pkg::MODE_EXTREMES, $urandom_range(0, 63), $urandom_range(0, 63),
                       16'($urandom));
         issue_request(tcm_pkg::MODE_CLUSTER, $urandom_range(0, 63), $urandom_range(0, 63),
                       16'($urandom));

         repeat (MIXED_PER_PHASE) begin
            pick = $urandom_range(0, 19);
            // Occasionally hold off until the block has answered everything
            if (pick == 0 && !calm)
               drain_answers();
            row = $urandom_range(0, DIM - 1);
            col = $urandom_range(0, DIM - 1);
            if (pick < 7) begin
               issue_request(tcm_pkg::MODE_WRITE, row, col, pick_value(style));
            end else if (pick < 12) begin
               issue_request(tcm_pkg::MODE_READ, row, col, 16'($urandom));
            end else if (pick < 14) begin
               issue_request(tcm_pkg::MODE_EXTREMES, $urandom_range(0, 63),
                             $urandom_range(0, 63), 16'($urandom));
            end else if (pick < 17) begin
               issue_request(tcm_pkg::MODE_CLUSTER, $urandom_range(0, 63),
                             $urandom_range(0, 63), 16'($urandom));
            end else begin
               // Push one index out of range
               if ($urandom_range(0, 1))
                  row = $urandom_range(DIM, 63);
               else
                  col = $urandom_range(DIM, 63);
               issue_request($urandom_range(0, 1) ? tcm_pkg::MODE_WRITE : tcm_pkg::MODE_READ,
                             row, col, 16'($urandom));
            end
         end
      end

      drain_answers();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("threshold_cluster_matrix regression: pass");
      else
         $display("threshold_cluster_matrix regression: fail");
      $finish;
   end

endmodule
